@@ rtl/core/pksw_pkg.sv @@
// shared constants, types and helpers of the per-key sliding window limiter
package pksw_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int LOG_DEPTH     = 64;
    localparam int TIME_BITS     = 48;
    localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
    localparam int LOG_BITS      = $clog2(LOG_DEPTH);
    localparam int FILL_BITS     = LOG_BITS + 1;
    localparam int KEY_BITS      = 64;
    localparam int CMD_BITS      = 2;
    localparam int MAXREQ_BITS   = 6;
    localparam int COUNT_BITS    = 7;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 48;
    localparam int STAMP_DEPTH   = TABLE_ENTRIES * LOG_DEPTH;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

    // command codes on the input channel
    localparam logic [CMD_BITS-1:0] CMD_CHECK   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_BLOCK   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_UNBLOCK = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_CLEAN   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAXREQ = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK  = 2'd2;

    typedef enum logic [2:0] {
        OP_CHECK,
        OP_PASS,
        OP_BLOCK,
        OP_UNBLOCK,
        OP_CLEAN
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [KEY_BITS-1:0]  key_high;
        logic [KEY_BITS-1:0]  key_low;
        logic [TIME_BITS-1:0] now_time;
        logic [TIME_BITS-1:0] block_time;
    } q_item_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } q_ctl_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key_high;
        logic [KEY_BITS-1:0]  key_low;
        logic [LOG_BITS-1:0]  head;
        logic [FILL_BITS-1:0] fill;
        logic [TIME_BITS-1:0] blocked;
    } meta_t;

    localparam int META_BITS = $bits(meta_t);

    typedef struct packed {
        logic                   limited;
        logic [COUNT_BITS-1:0]  req_count;
        logic [MAXREQ_BITS-1:0] remaining;
        logic [TIME_BITS-1:0]   retry_after;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_CHK,
        ST_DROP_RD,
        ST_DROP_CMP,
        ST_APPEND,
        ST_CHK_END,
        ST_BLK,
        ST_CLN_RD,
        ST_CLN_LD,
        ST_CLN_END,
        ST_DONE
    } state_t;

    // time plus duration, saturating at the largest time value
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/pksw_if.sv @@
// channel interfaces: request, result and configuration write
interface pksw_in_if;
    import pksw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_BITS-1:0]  cmd;
    logic [KEY_BITS-1:0]  ip_high;
    logic [KEY_BITS-1:0]  ip_low;
    logic [TIME_BITS-1:0] now_time;
    logic [TIME_BITS-1:0] block_time;
    logic                 bypass;
    modport source (output valid, cmd, ip_high, ip_low, now_time, block_time, bypass,
                    input ready);
    modport sink (input valid, cmd, ip_high, ip_low, now_time, block_time, bypass,
                  output ready);
endinterface

interface pksw_out_if;
    import pksw_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   limited;
    logic [COUNT_BITS-1:0]  req_count;
    logic [MAXREQ_BITS-1:0] remaining;
    logic [TIME_BITS-1:0]   retry_after;
    modport source (output valid, limited, req_count, remaining, retry_after,
                    input ready);
    modport sink (input valid, limited, req_count, remaining, retry_after,
                  output ready);
endinterface

interface pksw_cfg_if;
    import pksw_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/pksw_ram.sv @@
// generic single write port ram with registered read
module pksw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/pksw_front.sv @@
// front end: accepts requests, classifies them and queues them for the engine
module pksw_front (
    input  logic              clk,
    input  logic              rst_n,
    pksw_in_if.sink           in_ch,
    output pksw_pkg::q_item_t q_item,
    input  logic              q_pop,
    output logic              q_valid
);
    import pksw_pkg::*;

    q_item_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   cnt_reg;
    q_item_t              cls_item;
    logic                 push;
    logic                 pop;

    // classify the command
    always_comb
    begin
        cls_item.key_high   = in_ch.ip_high;
        cls_item.key_low    = in_ch.ip_low;
        cls_item.now_time   = in_ch.now_time;
        cls_item.block_time = in_ch.block_time;
        unique case (in_ch.cmd)
            CMD_CHECK:   cls_item.op = in_ch.bypass ? OP_PASS : OP_CHECK;
            CMD_BLOCK:   cls_item.op = OP_BLOCK;
            CMD_UNBLOCK: cls_item.op = OP_UNBLOCK;
            CMD_CLEAN:   cls_item.op = OP_CLEAN;
            default:     cls_item.op = OP_CLEAN;
        endcase
    end

    assign in_ch.ready = (cnt_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign pop         = q_pop && q_valid;
    assign q_item      = entries_reg[rd_ptr_reg];

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= cls_item;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

@@ rtl/core/pksw_back.sv @@
// back end: table lookup, timestamp ring update, commands and result register
module pksw_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pksw_pkg::q_item_t q_item,
    input  logic              q_valid,
    output logic              q_pop,
    pksw_cfg_if.sink          cfg_ch,
    pksw_out_if.source        out_ch
);
    import pksw_pkg::*;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_ENTRIES - 1);
    localparam logic [FILL_BITS-1:0] FULL_FILL = FILL_BITS'(LOG_DEPTH);

    state_t                   state_reg, state_next;
    q_item_t                  item_reg, item_next;
    meta_t                    meta_reg, meta_next;
    logic [SLOT_BITS-1:0]     slot_reg, slot_next;
    logic [SLOT_BITS-1:0]     scan_reg, scan_next;
    logic                     iss_reg, iss_next;
    logic                     rd_on_reg, rd_on_next;
    logic [SLOT_BITS-1:0]     rd_idx_reg, rd_idx_next;
    logic                     free_found_reg, free_found_next;
    logic [SLOT_BITS-1:0]     free_slot_reg, free_slot_next;
    logic                     found_reg, found_next;
    logic [SLOT_BITS-1:0]     evict_reg, evict_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [TIME_BITS-1:0]     cutoff_reg, cutoff_next;
    logic                     win_ok_reg, win_ok_next;
    result_t                  res_reg, res_next;
    result_t                  out_reg, out_next;
    logic                     ovalid_reg, ovalid_next;
    logic [TIME_BITS-1:0]     window_reg;
    logic [MAXREQ_BITS-1:0]   maxreq_reg;
    logic [TIME_BITS-1:0]     blockt_reg;

    logic                     meta_we;
    meta_t                    meta_wr;
    logic [META_BITS-1:0]     meta_rdata;
    meta_t                    meta_rd;
    logic                     stamp_we;
    logic [LOG_BITS-1:0]      stamp_pos;
    logic [TIME_BITS-1:0]     stamp_wdata;
    logic [TIME_BITS-1:0]     stamp_rdata;
    logic                     hit;
    logic                     have_free;
    logic [LOG_BITS-1:0]      app_head;
    logic [FILL_BITS-1:0]     app_fill;
    logic [TIME_BITS-1:0]     dur;
    logic [TIME_BITS-1:0]     cln_blocked;
    logic                     out_free;

    assign meta_rd = meta_t'(meta_rdata);

    // entry table: key, ring head, fill and block time per slot
    pksw_ram #(
        .WIDTH (META_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (slot_reg),
        .wdata (meta_wr),
        .raddr (scan_reg),
        .rdata (meta_rdata)
    );

    // timestamp rings, one row per slot
    pksw_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (STAMP_DEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr ({slot_reg, stamp_pos}),
        .wdata (stamp_wdata),
        .raddr ({slot_reg, meta_reg.head}),
        .rdata (stamp_rdata)
    );

    // configuration registers
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= TIME_BITS'(60000);
            maxreq_reg <= MAXREQ_BITS'(60);
            blockt_reg <= TIME_BITS'(60000);
        end
        else if (cfg_ch.valid)
        begin
            if (cfg_ch.index == CFG_WINDOW)
            begin
                window_reg <= cfg_ch.data[TIME_BITS-1:0];
            end
            else if (cfg_ch.index == CFG_MAXREQ)
            begin
                maxreq_reg <= cfg_ch.data[MAXREQ_BITS-1:0];
            end
            else if (cfg_ch.index == CFG_BLOCK)
            begin
                blockt_reg <= cfg_ch.data[TIME_BITS-1:0];
            end
        end
    end

    // helpers
    assign hit = rd_on_reg && valid_reg[rd_idx_reg]
                 && (meta_rd.key_high == item_reg.key_high)
                 && (meta_rd.key_low == item_reg.key_low);
    assign have_free = free_found_reg || !valid_reg[rd_idx_reg];
    assign dur = (item_reg.block_time != '0) ? item_reg.block_time : blockt_reg;
    assign cln_blocked = (item_reg.now_time >= meta_reg.blocked) ? '0 : meta_reg.blocked;
    assign out_free = !ovalid_reg || out_ch.ready;

    // ring append position
    always_comb
    begin
        if (meta_reg.fill == FULL_FILL)
        begin
            app_head = meta_reg.head + 1'b1;
            app_fill = FULL_FILL - 1'b1;
        end
        else
        begin
            app_head = meta_reg.head;
            app_fill = meta_reg.fill;
        end
        stamp_pos = app_head + app_fill[LOG_BITS-1:0];
    end

    // engine state machine
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        meta_next       = meta_reg;
        slot_next       = slot_reg;
        scan_next       = scan_reg;
        iss_next        = iss_reg;
        rd_on_next      = 1'b0;
        rd_idx_next     = rd_idx_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        found_next      = found_reg;
        evict_next      = evict_reg;
        valid_next      = valid_reg;
        cutoff_next     = cutoff_reg;
        win_ok_next     = win_ok_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        ovalid_next     = ovalid_reg && !out_ch.ready;
        q_pop           = 1'b0;
        meta_we         = 1'b0;
        meta_wr         = meta_reg;
        stamp_we        = 1'b0;
        stamp_wdata     = item_reg.now_time;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                res_next        = '0;
                cutoff_next     = item_reg.now_time - window_reg;
                win_ok_next     = (item_reg.now_time >= window_reg);
                scan_next       = '0;
                iss_next        = 1'b1;
                free_found_next = 1'b0;
                priority case (item_reg.op)
                    OP_PASS:  state_next = ST_DONE;
                    OP_CLEAN: state_next = ST_CLN_RD;
                    default:  state_next = ST_SCAN;
                endcase
            end
            ST_SCAN:
            begin
                // issue reads in order, compare each in the next cycle
                if (iss_reg)
                begin
                    rd_on_next  = 1'b1;
                    rd_idx_next = scan_reg;
                    scan_next   = scan_reg + 1'b1;
                    iss_next    = (scan_reg != LAST_SLOT);
                end
                if (rd_on_reg && !valid_reg[rd_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_slot_next  = rd_idx_reg;
                end
                if (hit)
                begin
                    found_next = 1'b1;
                    slot_next  = rd_idx_reg;
                    meta_next  = meta_rd;
                    iss_next   = 1'b0;
                    rd_on_next = 1'b0;
                    priority case (item_reg.op)
                        OP_CHECK: state_next = ST_CHK;
                        OP_BLOCK: state_next = ST_BLK;
                        default:
                        begin
                            valid_next[rd_idx_reg] = 1'b0;
                            state_next             = ST_DONE;
                        end
                    endcase
                end
                else if (rd_on_reg && rd_idx_reg == LAST_SLOT)
                begin
                    found_next = 1'b0;
                    if (item_reg.op == OP_UNBLOCK)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // new key: lowest free slot, else round-robin eviction
                        if (have_free)
                        begin
                            slot_next = free_found_reg ? free_slot_reg : rd_idx_reg;
                            valid_next[free_found_reg ? free_slot_reg : rd_idx_reg] = 1'b1;
                        end
                        else
                        begin
                            slot_next             = evict_reg;
                            valid_next[evict_reg] = 1'b1;
                            evict_next            = evict_reg + 1'b1;
                        end
                        meta_next.key_high = item_reg.key_high;
                        meta_next.key_low  = item_reg.key_low;
                        meta_next.head     = '0;
                        meta_next.fill     = '0;
                        meta_next.blocked  = '0;
                        state_next = (item_reg.op == OP_CHECK) ? ST_CHK : ST_BLK;
                    end
                end
            end
            ST_CHK:
            begin
                if (found_reg && meta_reg.blocked > item_reg.now_time)
                begin
                    res_next.limited     = 1'b1;
                    res_next.req_count   = COUNT_BITS'(maxreq_reg);
                    res_next.retry_after = meta_reg.blocked - item_reg.now_time;
                    state_next           = ST_DONE;
                end
                else
                begin
                    meta_next.blocked = '0;
                    state_next        = win_ok_reg ? ST_DROP_RD : ST_APPEND;
                end
            end
            ST_DROP_RD:
            begin
                // stamp read of the ring head is in flight
                if (meta_reg.fill == '0)
                begin
                    state_next = (item_reg.op == OP_CLEAN) ? ST_CLN_END : ST_APPEND;
                end
                else
                begin
                    state_next = ST_DROP_CMP;
                end
            end
            ST_DROP_CMP:
            begin
                if (stamp_rdata <= cutoff_reg)
                begin
                    meta_next.head = meta_reg.head + 1'b1;
                    meta_next.fill = meta_reg.fill - 1'b1;
                    state_next     = ST_DROP_RD;
                end
                else
                begin
                    state_next = (item_reg.op == OP_CLEAN) ? ST_CLN_END : ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                stamp_we       = 1'b1;
                meta_next.head = app_head;
                meta_next.fill = app_fill + 1'b1;
                state_next     = ST_CHK_END;
            end
            ST_CHK_END:
            begin
                res_next.req_count = COUNT_BITS'(meta_reg.fill);
                if (meta_reg.fill > FILL_BITS'(maxreq_reg))
                begin
                    meta_wr.blocked      = sat_add(item_reg.now_time, blockt_reg);
                    res_next.limited     = 1'b1;
                    res_next.retry_after = blockt_reg;
                end
                else
                begin
                    res_next.remaining = maxreq_reg - meta_reg.fill[MAXREQ_BITS-1:0];
                end
                meta_we    = 1'b1;
                state_next = ST_DONE;
            end
            ST_BLK:
            begin
                meta_wr.blocked = sat_add(item_reg.now_time, dur);
                meta_we         = 1'b1;
                state_next      = ST_DONE;
            end
            ST_CLN_RD:
            begin
                if (valid_reg[scan_reg])
                begin
                    state_next = ST_CLN_LD;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_CLN_LD:
            begin
                meta_next  = meta_rd;
                slot_next  = scan_reg;
                state_next = win_ok_reg ? ST_DROP_RD : ST_CLN_END;
            end
            ST_CLN_END:
            begin
                meta_wr.blocked = cln_blocked;
                meta_we         = 1'b1;
                if (meta_reg.fill == '0 && cln_blocked == '0)
                begin
                    valid_next[slot_reg] = 1'b0;
                end
                if (scan_reg == LAST_SLOT)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_CLN_RD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next    = res_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result channel
    assign out_ch.valid       = ovalid_reg;
    assign out_ch.limited     = out_reg.limited;
    assign out_ch.req_count   = out_reg.req_count;
    assign out_ch.remaining   = out_reg.remaining;
    assign out_ch.retry_after = out_reg.retry_after;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            evict_reg  <= '0;
            ovalid_reg <= 1'b0;
            iss_reg    <= 1'b0;
            rd_on_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            evict_reg  <= evict_next;
            ovalid_reg <= ovalid_next;
            iss_reg    <= iss_next;
            rd_on_reg  <= rd_on_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        meta_reg       <= meta_next;
        slot_reg       <= slot_next;
        scan_reg       <= scan_next;
        rd_idx_reg     <= rd_idx_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        found_reg      <= found_next;
        cutoff_reg     <= cutoff_next;
        win_ok_reg     <= win_ok_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end
endmodule

@@ rtl/core/per_key_sliding_window_limiter.sv @@
// per-key sliding window rate limiter, top level
// a check or block of a new key scans all 64 slots; a key found in slot k ends the scan there,
// and each expired timestamp dropped adds a ring read and a compare
// bypass check skips the table; cleanup walks all 64 slots and rewrites each live slot
// throughput: one transaction in the engine at a time, two more held in the input queue
// reset clears slot valid bits and eviction pointer, loads register defaults; no clearing pass
module per_key_sliding_window_limiter (
    input  logic       clk,
    input  logic       rst_n,
    pksw_in_if.sink    in_ch,
    pksw_out_if.source out_ch,
    pksw_cfg_if.sink   cfg_ch
);
    import pksw_pkg::*;

    q_item_t q_item;
    q_ctl_t  q_ctl;

    // request intake and queue
    pksw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_item  (q_item),
        .q_pop   (q_ctl.pop),
        .q_valid (q_ctl.valid)
    );

    // table engine
    pksw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_valid (q_ctl.valid),
        .q_pop   (q_ctl.pop),
        .cfg_ch  (cfg_ch),
        .out_ch  (out_ch)
    );
endmodule

@@ sim/pksw_checker.sv @@
// result checker: watches the channels, predicts each result and compares
module pksw_checker (
    input  logic clk,
    input  logic rst_n,
    pksw_in_if   in_ch,
    pksw_out_if  out_ch,
    pksw_cfg_if  cfg_ch,
    output int   errors,
    output int   pending,
    output int   results_seen,
    output int   limited_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import pksw_pkg::*;

    // predicted copy of the limiter state
    logic                 slot_used [TABLE_ENTRIES];
    logic [KEY_BITS-1:0]  slot_kh [TABLE_ENTRIES];
    logic [KEY_BITS-1:0]  slot_kl [TABLE_ENTRIES];
    logic [TIME_BITS-1:0] stamps [TABLE_ENTRIES][LOG_DEPTH];
    int unsigned          ring_head [TABLE_ENTRIES];
    int unsigned          ring_fill [TABLE_ENTRIES];
    logic [TIME_BITS-1:0] hold_until [TABLE_ENTRIES];
    int unsigned          victim;
    logic [TIME_BITS-1:0] window_len;
    int unsigned          allowed;
    logic [TIME_BITS-1:0] penalty;
    result_t              expected_results [$];

    // time plus duration, clamped at the top of the time range
    function automatic logic [TIME_BITS-1:0] clamp_sum(logic [TIME_BITS-1:0] a,
                                                       logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

    function automatic int lookup(logic [KEY_BITS-1:0] kh, logic [KEY_BITS-1:0] kl);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_used[i] && slot_kh[i] == kh && slot_kl[i] == kl)
                return i;
        return -1;
    endfunction

    // lowest free slot, else round-robin replacement
    function automatic int claim(logic [KEY_BITS-1:0] kh, logic [KEY_BITS-1:0] kl);
        int s;
        s = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!slot_used[i])
            begin
                s = i;
                break;
            end
        if (s < 0)
        begin
            s = int'(victim);
            victim = (victim + 1) % TABLE_ENTRIES;
        end
        slot_used[s] = 1'b1;
        slot_kh[s] = kh;
        slot_kl[s] = kl;
        ring_head[s] = 0;
        ring_fill[s] = 0;
        hold_until[s] = '0;
        return s;
    endfunction

    // pop timestamps at or before now minus window
    function automatic void expire(int s, logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] cutoff;
        if (now < window_len)
            return;
        cutoff = now - window_len;
        while (ring_fill[s] > 0 && stamps[s][ring_head[s]] <= cutoff)
        begin
            ring_head[s] = (ring_head[s] + 1) % LOG_DEPTH;
            ring_fill[s]--;
        end
    endfunction

    function automatic void record(int s, logic [TIME_BITS-1:0] now);
        if (ring_fill[s] >= LOG_DEPTH)
        begin
            ring_head[s] = (ring_head[s] + 1) % LOG_DEPTH;
            ring_fill[s] = LOG_DEPTH - 1;
        end
        stamps[s][(ring_head[s] + ring_fill[s]) % LOG_DEPTH] = now;
        ring_fill[s]++;
    endfunction

    // admission decision and state update for one transaction
    function automatic result_t admit(logic [CMD_BITS-1:0] cmd, logic [KEY_BITS-1:0] kh,
                                      logic [KEY_BITS-1:0] kl, logic [TIME_BITS-1:0] now,
                                      logic [TIME_BITS-1:0] bt, logic bypass);
        result_t r;
        int s;
        r = '0;
        if (cmd == CMD_CHECK)
        begin
            if (!bypass)
            begin
                s = lookup(kh, kl);
                if (s >= 0 && hold_until[s] > now)
                begin
                    r.limited = 1'b1;
                    r.req_count = COUNT_BITS'(allowed);
                    r.retry_after = hold_until[s] - now;
                end
                else
                begin
                    if (s >= 0)
                        hold_until[s] = '0;
                    else
                        s = claim(kh, kl);
                    expire(s, now);
                    record(s, now);
                    r.req_count = COUNT_BITS'(ring_fill[s]);
                    if (ring_fill[s] > allowed)
                    begin
                        hold_until[s] = clamp_sum(now, penalty);
                        r.limited = 1'b1;
                        r.retry_after = penalty;
                    end
                    else
                        r.remaining = MAXREQ_BITS'(allowed - ring_fill[s]);
                end
            end
        end
        else if (cmd == CMD_BLOCK)
        begin
            s = lookup(kh, kl);
            if (s < 0)
                s = claim(kh, kl);
            hold_until[s] = clamp_sum(now, (bt != 0) ? bt : penalty);
        end
        else if (cmd == CMD_UNBLOCK)
        begin
            s = lookup(kh, kl);
            if (s >= 0)
            begin
                slot_used[s] = 1'b0;
                ring_fill[s] = 0;
                ring_head[s] = 0;
                hold_until[s] = '0;
            end
        end
        else
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (!slot_used[i])
                    continue;
                expire(i, now);
                if (now >= hold_until[i])
                    hold_until[i] = '0;
                if (ring_fill[i] == 0 && hold_until[i] == 0)
                begin
                    slot_used[i] = 1'b0;
                    ring_head[i] = 0;
                end
            end
        end
        return r;
    endfunction

    function automatic void compare_field(string name, logic [TIME_BITS-1:0] exp_v,
                                          logic [TIME_BITS-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // watch the channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_used[i] = 1'b0;
                ring_head[i] = 0;
                ring_fill[i] = 0;
                hold_until[i] = '0;
            end
            victim = 0;
            window_len = 48'd60000;
            allowed = 60;
            penalty = 48'd60000;
            expected_results.delete();
            errors = 0;
            results_seen = 0;
            limited_seen = 0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_WINDOW: window_len = cfg_ch.data[TIME_BITS-1:0];
                    CFG_MAXREQ: allowed = 32'(cfg_ch.data[MAXREQ_BITS-1:0]);
                    CFG_BLOCK:  penalty = cfg_ch.data[TIME_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (out_ch.limited)
                    limited_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %0h %0h %0h %0h",
                             $time, out_ch.limited, out_ch.req_count, out_ch.remaining,
                             out_ch.retry_after);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    compare_field("limited", exp_r.limited, out_ch.limited);
                    compare_field("req_count", exp_r.req_count, out_ch.req_count);
                    compare_field("remaining", exp_r.remaining, out_ch.remaining);
                    compare_field("retry_after", exp_r.retry_after, out_ch.retry_after);
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_results.insert(expected_results.size(),
                                        admit(in_ch.cmd, in_ch.ip_high, in_ch.ip_low,
                                              in_ch.now_time, in_ch.block_time,
                                              in_ch.bypass));
        end
        pending = expected_results.size();
    end

endmodule

@@ sim/testbench.sv @@
// testbench top: clock, reset, stimulus and verdict for the limiter
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pksw_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam logic [TIME_BITS-1:0]    TMAX = {TIME_BITS{1'b1}};
    localparam int POOL_KEYS = 80;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 190;
    localparam int DRAIN_CYCLES = 400;

    logic clk;
    logic rst_n;
    int   errors, pending, results_seen, limited_seen;
    int   send_idle, recv_stall;
    int   items_sent;

    logic [KEY_BITS-1:0]  pool_kh [POOL_KEYS];
    logic [KEY_BITS-1:0]  pool_kl [POOL_KEYS];
    logic [TIME_BITS-1:0] clock_now;

    pksw_in_if  in_ch ();
    pksw_out_if out_ch ();
    pksw_cfg_if cfg_ch ();

    per_key_sliding_window_limiter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    pksw_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .limited_seen (limited_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side back-pressure
    always @(posedge clk)
        out_ch.ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);

    // send one request transaction, with optional idle cycles ahead of it
    task automatic send(logic [CMD_BITS-1:0] cmd, int key, logic [TIME_BITS-1:0] now,
                        logic [TIME_BITS-1:0] bt, logic byp);
        logic got;
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.ip_high    <= pool_kh[key];
        in_ch.ip_low     <= pool_kl[key];
        in_ch.now_time   <= now;
        in_ch.block_time <= bt;
        in_ch.bypass     <= byp;
        do
        begin
            @(negedge clk);
            got = in_ch.ready;
            @(posedge clk);
        end
        while (!got);
        items_sent++;
    endtask

    // stop sending and let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all three registers plus the unused index, back to back
    task automatic write_regs(logic [TIME_BITS-1:0] win, int maxreq,
                              logic [TIME_BITS-1:0] blk);
        logic [CFG_IDX_BITS-1:0]  idx [4];
        logic [CFG_DATA_BITS-1:0] val [4];
        logic got;
        idx = '{CFG_WINDOW, CFG_MAXREQ, CFG_BLOCK, CFG_SPARE};
        val = '{win, CFG_DATA_BITS'(maxreq), blk, CFG_DATA_BITS'({$urandom, $urandom})};
        for (int i = 0; i < 4; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do
            begin
                @(negedge clk);
                got = cfg_ch.ready;
                @(posedge clk);
            end
            while (!got);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // random request with hot keys, drifting time and mixed commands
    task automatic random_item(int tstep);
        int r, key;
        logic [CMD_BITS-1:0]  cmd;
        logic [TIME_BITS-1:0] now, bt;
        key = ($urandom_range(99) < 55) ? $urandom_range(3) : $urandom_range(POOL_KEYS - 1);
        r = $urandom_range(99);
        cmd = (r < 72) ? CMD_CHECK : (r < 80) ? CMD_BLOCK : (r < 88) ? CMD_UNBLOCK : CMD_CLEAN;
        clock_now = clock_now + TIME_BITS'($urandom_range(tstep));
        now = ($urandom_range(99) < 2) ? TIME_BITS'({$urandom, $urandom}) : clock_now;
        r = $urandom_range(99);
        bt = (r < 30) ? '0 : (r < 40) ? TMAX : (r < 50) ? TIME_BITS'({$urandom, $urandom})
                                      : TIME_BITS'($urandom_range(4 * tstep));
        send(cmd, key, now, bt, $urandom_range(99) < 5);
    endtask

    // stimulus and verdict
    initial
    begin
        logic [TIME_BITS-1:0] win_set [PHASES];
        int                   max_set [PHASES];
        logic [TIME_BITS-1:0] blk_set [PHASES];
        int                   step_set [PHASES];
        win_set  = '{48'd60000, 48'd1000, 48'd1, TMAX, 48'd500, 48'd20000, 48'd100, 48'd5000};
        max_set  = '{60, 5, 1, 63, 3, 10, 63, 2};
        blk_set  = '{48'd60000, 48'd3000, 48'd0, TMAX, TMAX, 48'd5000, 48'd1, 48'd10000};
        step_set = '{200, 100, 1, 1000, 50, 300, 2, 100};

        for (int i = 0; i < POOL_KEYS; i++)
        begin
            pool_kh[i] = {$urandom, $urandom};
            pool_kl[i] = {$urandom, $urandom};
        end
        pool_kh[4] = '0;
        pool_kl[4] = '0;
        pool_kh[5] = '1;
        pool_kl[5] = '1;
        pool_kh[6] = '0;

        items_sent = 0;
        send_idle = 0;
        recv_stall = 0;
        clock_now = 48'd1000;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.cmd <= CMD_CHECK;
        in_ch.ip_high <= '0;
        in_ch.ip_low <= '0;
        in_ch.now_time <= '0;
        in_ch.block_time <= '0;
        in_ch.bypass <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_WINDOW;
        cfg_ch.data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bypass, extreme keys, manual blocks, unblock, cleanup
        send(CMD_CHECK, 0, 48'd100, '0, 1'b1);
        send(CMD_CHECK, 4, 48'd0, '0, 1'b0);
        send(CMD_CHECK, 5, TMAX, TMAX, 1'b0);
        send(CMD_BLOCK, 1, 48'd1000, '0, 1'b0);
        send(CMD_CHECK, 1, 48'd1001, '0, 1'b0);
        send(CMD_BLOCK, 2, TMAX, TMAX, 1'b0);
        send(CMD_CHECK, 2, TMAX - 1, '0, 1'b0);
        send(CMD_UNBLOCK, 1, 48'd1002, '0, 1'b0);
        send(CMD_UNBLOCK, 7, 48'd1002, '0, 1'b0);
        send(CMD_CHECK, 1, 48'd1003, '0, 1'b0);
        send(CMD_CHECK, 6, 48'd1004, '0, 1'b1);
        send(CMD_CLEAN, 0, 48'd200000, '0, 1'b0);
        send(CMD_CHECK, 2, 48'd5, '0, 1'b0);
        send(CMD_CHECK, 1, 48'd61003, '0, 1'b0);
        send(CMD_CLEAN, 3, TMAX, '0, 1'b0);
        send(CMD_CHECK, 2, 48'd6, '0, 1'b0);
        drain();

        // random phases, each under its own register setting and one of four idling patterns
        for (int p = 0; p < PHASES; p++)
        begin
            write_regs(win_set[p], max_set[p], blk_set[p]);
            send_idle  = (p % 4 == 1) ? 63 : (p % 4 == 3) ? 28 : 0;
            recv_stall = (p % 4 == 2) ? 63 : (p % 4 == 3) ? 28 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item(step_set[p]);
            drain();
        end

        $display("%0d requests sent over %0d register settings; %0d results, %0d limited",
                 items_sent, PHASES + 1, results_seen, limited_seen);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pksw_pkg.sv
rtl/core/pksw_if.sv
rtl/core/pksw_ram.sv
rtl/core/pksw_front.sv
rtl/core/pksw_back.sv
rtl/core/per_key_sliding_window_limiter.sv
sim/pksw_checker.sv
sim/testbench.sv
